// ===== rtl/ora_pkg.sv =====
// Shared types and constants for the orientation rate averager.
`default_nettype none
package ora_pkg;

  // fixed field widths
  localparam int QUAT_BITS = 16;
  localparam int FRAC_BITS = QUAT_BITS - 2;
  localparam int ROT_BITS  = QUAT_BITS + 2;
  localparam int RAW_BITS  = 2 * QUAT_BITS + 3;
  localparam int RATE_BITS = 32;
  localparam int OUT_BITS  = 32;
  localparam int STAMP_BITS = 32;

  // serial multiplier operand widths
  localparam int MUL_AW = 27;
  localparam int MUL_BW = 20;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  // serial divider widths
  localparam int DIV_NW_MIN = 44;
  localparam int DIV_DW = 34;

  // rate sum accumulator and its rounded form
  localparam int ACC_BITS = 40;
  localparam int S_BITS = ACC_BITS - FRAC_BITS;

  // 1024000000 / 2^13, numerator scale after cancelling the common power of two
  localparam logic [MUL_BW-1:0] RATE_MULT = MUL_BW'(125000);

  // configuration register indexes
  localparam logic [1:0] CFG_WINDOW_LENGTH = 2'd0;
  localparam logic [1:0] CFG_MIN_INTERVAL  = 2'd1;
  localparam int CFG_DATA_BITS = 16;

  typedef struct packed {
    logic [STAMP_BITS-1:0]       stamp_us;
    logic signed [QUAT_BITS-1:0] quat_w;
    logic signed [QUAT_BITS-1:0] quat_x;
    logic signed [QUAT_BITS-1:0] quat_y;
    logic signed [QUAT_BITS-1:0] quat_z;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] rate_x;
    logic signed [OUT_BITS-1:0] rate_y;
    logic signed [OUT_BITS-1:0] rate_z;
    logic                       rate_valid;
    logic                       sample_taken;
  } out_item_t;

endpackage
`default_nettype wire

// ===== rtl/ora_serial_mul.sv =====
// Bit-serial signed shift-add multiplier, one multiplier bit per cycle.
`default_nettype none
module ora_serial_mul
  import ora_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic signed [MUL_AW-1:0] op_a,
  input  wire logic signed [MUL_BW-1:0] op_b,
  output logic                          done,
  output logic signed [MUL_PW-1:0]      prod
);

  localparam int CW = $clog2(MUL_BW + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [MUL_PW-1:0] mc_r, mc_nxt;
  logic [MUL_BW-1:0] mp_r, mp_nxt;
  logic [MUL_PW-1:0] acc_r, acc_nxt;
  logic              neg_r, neg_nxt;
  logic [MUL_AW-1:0] mag_a;
  logic [MUL_BW-1:0] mag_b;

  // take magnitudes; sign is applied at the end
  assign mag_a = op_a[MUL_AW-1] ? MUL_AW'(-op_a) : MUL_AW'(op_a);
  assign mag_b = op_b[MUL_BW-1] ? MUL_BW'(-op_b) : MUL_BW'(op_b);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    mc_nxt   = mc_r;
    mp_nxt   = mp_r;
    acc_nxt  = acc_r;
    neg_nxt  = neg_r;
    if (start && !busy_r) begin
      // load operands
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      mc_nxt   = {{MUL_BW{1'b0}}, mag_a};
      mp_nxt   = mag_b;
      acc_nxt  = '0;
      neg_nxt  = op_a[MUL_AW-1] ^ op_b[MUL_BW-1];
    end else if (busy_r) begin
      // add shifted multiplicand, advance one bit
      if (mp_r[0]) begin
        acc_nxt = acc_r + mc_r;
      end
      mc_nxt  = {mc_r[MUL_PW-2:0], 1'b0};
      mp_nxt  = {1'b0, mp_r[MUL_BW-1:1]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(MUL_BW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    mc_r  <= mc_nxt;
    mp_r  <= mp_nxt;
    acc_r <= acc_nxt;
    neg_r <= neg_nxt;
  end

  assign done = done_r;
  assign prod = neg_r ? -$signed(acc_r) : $signed(acc_r);

endmodule
`default_nettype wire

// ===== rtl/ora_serial_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module ora_serial_div
  import ora_pkg::*;
#(
  parameter int NW = 44
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [NW-1:0]     num,
  input  wire logic [DIV_DW-1:0] den,
  output logic                   done,
  output logic [NW-1:0]          quot
);

  localparam int CW = $clog2(NW + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [NW-1:0]     num_r, num_nxt;
  logic [DIV_DW:0]   rem_r, rem_nxt;
  logic [DIV_DW-1:0] den_r, den_nxt;
  logic [DIV_DW:0]   rem_sh;
  logic              qbit;

  // shift in the next numerator bit and try the subtraction
  assign rem_sh = {rem_r[DIV_DW-1:0], num_r[NW-1]};
  assign qbit   = (rem_sh >= {1'b0, den_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      num_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      rem_nxt = qbit ? (rem_sh - {1'b0, den_r}) : rem_sh;
      num_nxt = {num_r[NW-2:0], qbit};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(NW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quot = num_r;

endmodule
`default_nettype wire

// ===== rtl/orientation_rate_averager.sv =====
// Top level: body rates from successive quaternion poses, moving-window mean.
//
//  channel  direction  handshake             payload
//  in_      input      in_valid / in_stall   in_data (in_item_t)
//  out_     output     out_valid / out_stall out_data (out_item_t)
//  cfg_     input      cfg_we                cfg_index, cfg_wdata
//
// One item at a time. From the input transfer to the registered result an item
// passes through nine products for the rotation matrix; when a sample is taken,
// per axis three products, one scale product and one quotient follow; then,
// unless the window is empty, one quotient per axis for the mean. The next input
// transfer can follow in the cycle after the result is registered. The multiplier
// and divider are bit-serial. Reset is synchronous and needs no clearing pass.
// A finished result waits in the output register while out_stall is high;
// the next item is taken meanwhile and waits at its end for that register.
`default_nettype none
module orientation_rate_averager
  import ora_pkg::*;
#(
  parameter int MAX_WINDOW = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire in_item_t                 in_data,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output out_item_t                     out_data,
  input  wire logic                     cfg_we,
  input  wire logic [1:0]               cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int HW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SUM_W = RATE_BITS + CNT_W;
  localparam int DIV_NW = (SUM_W + 1 > DIV_NW_MIN) ? SUM_W + 1 : DIV_NW_MIN;
  localparam int LEN_RST = (MAX_WINDOW < 10) ? MAX_WINDOW : 10;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_QMUL  = 4'd1;
  localparam logic [3:0] S_ROT   = 4'd2;
  localparam logic [3:0] S_RMUL  = 4'd3;
  localparam logic [3:0] S_SCALE = 4'd4;
  localparam logic [3:0] S_RDIV  = 4'd5;
  localparam logic [3:0] S_UPD   = 4'd6;
  localparam logic [3:0] S_MDIV  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  typedef logic signed [ROT_BITS-1:0] rot_t;

  // control
  logic [3:0]       st_r, st_nxt;
  logic [3:0]       idx_r, idx_nxt;
  logic [1:0]       ax_r, ax_nxt;
  logic [1:0]       k_r, k_nxt;
  logic             pend_r, pend_nxt;
  logic             first_r, first_nxt;
  logic             taken_r, taken_nxt;
  logic [CNT_W-1:0] len_r, len_nxt;
  logic [CFG_DATA_BITS-1:0] minint_r, minint_nxt;
  logic [HW-1:0]    head_r, head_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  // payload
  in_item_t                 inb_r, inb_nxt;
  logic signed [31:0]       qp_r [9];
  logic signed [31:0]       qp_nxt [9];
  rot_t                     rot_r [9];
  rot_t                     rot_nxt [9];
  rot_t                     prev_r [9];
  rot_t                     prev_nxt [9];
  logic [STAMP_BITS-1:0]    pstamp_r, pstamp_nxt;
  logic signed [SUM_W-1:0]  sums_r [3];
  logic signed [SUM_W-1:0]  sums_nxt [3];
  logic signed [RATE_BITS-1:0] smp_r [3];
  logic signed [RATE_BITS-1:0] smp_nxt [3];
  logic signed [OUT_BITS-1:0]  mean_r [3];
  logic signed [OUT_BITS-1:0]  mean_nxt [3];
  logic signed [ACC_BITS-1:0]  acc_r, acc_nxt;
  logic             sneg_r, sneg_nxt;
  logic [DIV_NW-1:0] scale_r, scale_nxt;
  out_item_t        out_r, out_nxt;

  // history memory
  logic [3*RATE_BITS-1:0] hist_mem [MAX_WINDOW];
  logic [3*RATE_BITS-1:0] hist_rd_r;
  logic                   hist_we;
  logic [3*RATE_BITS-1:0] hist_wdata;

  // shared units
  logic                     mul_start, mul_done;
  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic signed [MUL_PW-1:0] mul_p;
  logic                     div_start, div_done;
  logic [DIV_NW-1:0]        div_num, div_q;
  logic [DIV_DW-1:0]        div_den;

  logic [STAMP_BITS-1:0] dt;
  logic signed [RAW_BITS-1:0] raw [9];
  logic [3:0]            ia, ib;
  logic signed [ROT_BITS:0] diff;
  logic signed [S_BITS-1:0] s_val;
  logic signed [SUM_W-1:0]  sum_sel;
  logic [SUM_W-1:0]         sum_mag;
  logic [RATE_BITS-1:0]     old_v [3];
  logic                     full;
  logic [4:0]               wl_v;

  ora_serial_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .done  (mul_done),
    .prod  (mul_p)
  );

  ora_serial_div #(
    .NW (DIV_NW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_q)
  );

  // round half up from Q.2F to Q.F, saturate to the matrix entry width
  function automatic rot_t rot_round(input logic signed [RAW_BITS-1:0] v);
    logic signed [RAW_BITS-1:0] t;
    logic signed [RAW_BITS-FRAC_BITS-1:0] q;
    t = v + RAW_BITS'(1 << (FRAC_BITS - 1));
    q = (RAW_BITS-FRAC_BITS)'(t >>> FRAC_BITS);
    if (!q[RAW_BITS-FRAC_BITS-1] && (|q[RAW_BITS-FRAC_BITS-2:ROT_BITS-1])) begin
      rot_round = {1'b0, {(ROT_BITS-1){1'b1}}};
    end else if (q[RAW_BITS-FRAC_BITS-1] && !(&q[RAW_BITS-FRAC_BITS-2:ROT_BITS-1])) begin
      rot_round = {1'b1, {(ROT_BITS-1){1'b0}}};
    end else begin
      rot_round = q[ROT_BITS-1:0];
    end
  endfunction

  // apply sign to a magnitude and saturate to w bits signed
  function automatic logic [DIV_NW-1:0] sat_signed(input logic [DIV_NW-1:0] q,
                                                   input logic neg, input int w);
    logic [DIV_NW-1:0] lim;
    logic [DIV_NW-1:0] r;
    lim = DIV_NW'(1) << (w - 1);
    if (neg) begin
      r = (q > lim) ? -lim : -q;
    end else begin
      r = (q >= lim) ? lim - 1'b1 : q;
    end
    sat_signed = r;
  endfunction

  // column picks: x uses (2,1), y uses (0,2), z uses (1,0)
  function automatic logic [1:0] col_a(input logic [1:0] a);
    case (a)
      2'd0:    col_a = 2'd2;
      2'd1:    col_a = 2'd0;
      default: col_a = 2'd1;
    endcase
  endfunction

  function automatic logic [1:0] col_b(input logic [1:0] a);
    case (a)
      2'd0:    col_b = 2'd1;
      2'd1:    col_b = 2'd2;
      default: col_b = 2'd0;
    endcase
  endfunction

  assign dt = inb_r.stamp_us - pstamp_r;
  assign ia = {2'b0, k_r} + {1'b0, k_r, 1'b0} + {2'b0, col_a(ax_r)};
  assign ib = {2'b0, k_r} + {1'b0, k_r, 1'b0} + {2'b0, col_b(ax_r)};
  assign diff = {rot_r[ib][ROT_BITS-1], rot_r[ib]} - {prev_r[ib][ROT_BITS-1], prev_r[ib]};
  assign s_val = S_BITS'((acc_r + ACC_BITS'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS);
  assign sum_sel = sums_r[ax_r];
  assign sum_mag = sum_sel[SUM_W-1] ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);
  assign full = (cnt_r >= len_r);
  assign wl_v = cfg_wdata[4:0];

  // matrix entries in Q.2F from the stored quaternion products
  always_comb begin
    logic signed [RAW_BITS-1:0] p [9];
    logic signed [RAW_BITS-1:0] one;
    for (int i = 0; i < 9; i++) begin
      p[i] = RAW_BITS'(qp_r[i]);
    end
    one = RAW_BITS'(1) <<< (2 * FRAC_BITS);
    raw[0] = one - ((p[1] + p[2]) <<< 1);
    raw[1] = (p[3] - p[8]) <<< 1;
    raw[2] = (p[4] + p[7]) <<< 1;
    raw[3] = (p[3] + p[8]) <<< 1;
    raw[4] = one - ((p[0] + p[2]) <<< 1);
    raw[5] = (p[5] - p[6]) <<< 1;
    raw[6] = (p[4] - p[7]) <<< 1;
    raw[7] = (p[5] + p[6]) <<< 1;
    raw[8] = one - ((p[0] + p[1]) <<< 1);
  end

  // unpack the entry that the head points to
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      old_v[a] = hist_rd_r[a*RATE_BITS +: RATE_BITS];
    end
  end

  // sequencer
  always_comb begin
    logic signed [QUAT_BITS-1:0] qa;
    logic signed [QUAT_BITS-1:0] qb;
    logic [DIV_NW-1:0] sv;

    st_nxt = st_r;
    idx_nxt = idx_r;
    ax_nxt = ax_r;
    k_nxt = k_r;
    pend_nxt = pend_r;
    first_nxt = first_r;
    taken_nxt = taken_r;
    len_nxt = len_r;
    minint_nxt = minint_r;
    head_nxt = head_r;
    cnt_nxt = cnt_r;
    out_valid_nxt = out_valid_r;
    inb_nxt = inb_r;
    qp_nxt = qp_r;
    rot_nxt = rot_r;
    prev_nxt = prev_r;
    pstamp_nxt = pstamp_r;
    sums_nxt = sums_r;
    smp_nxt = smp_r;
    mean_nxt = mean_r;
    acc_nxt = acc_r;
    sneg_nxt = sneg_r;
    scale_nxt = scale_r;
    out_nxt = out_r;
    mul_start = 1'b0;
    mul_a = '0;
    mul_b = '0;
    div_start = 1'b0;
    div_num = '0;
    div_den = '0;
    hist_we = 1'b0;
    hist_wdata = '0;
    qa = '0;
    qb = '0;
    sv = '0;

    // drop the result once transferred
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // configuration writes; the user must make them only while idle, which the block does not enforce
    if (cfg_we) begin
      if (cfg_index == CFG_WINDOW_LENGTH) begin
        if (wl_v == 5'd0) begin
          len_nxt = CNT_W'(1);
        end else if (32'(wl_v) > 32'(MAX_WINDOW)) begin
          len_nxt = CNT_W'(MAX_WINDOW);
        end else begin
          len_nxt = CNT_W'(wl_v);
        end
        head_nxt = '0;
        cnt_nxt = '0;
        for (int a = 0; a < 3; a++) begin
          sums_nxt[a] = '0;
        end
      end else if (cfg_index == CFG_MIN_INTERVAL) begin
        minint_nxt = cfg_wdata;
      end
    end

    case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          inb_nxt = in_data;
          idx_nxt = '0;
          pend_nxt = 1'b0;
          st_nxt = S_QMUL;
        end
      end

      S_QMUL: begin
        // quaternion products xx yy zz xy xz yz wx wy wz
        case (idx_r)
          4'd0:    begin qa = inb_r.quat_x; qb = inb_r.quat_x; end
          4'd1:    begin qa = inb_r.quat_y; qb = inb_r.quat_y; end
          4'd2:    begin qa = inb_r.quat_z; qb = inb_r.quat_z; end
          4'd3:    begin qa = inb_r.quat_x; qb = inb_r.quat_y; end
          4'd4:    begin qa = inb_r.quat_x; qb = inb_r.quat_z; end
          4'd5:    begin qa = inb_r.quat_y; qb = inb_r.quat_z; end
          4'd6:    begin qa = inb_r.quat_w; qb = inb_r.quat_x; end
          4'd7:    begin qa = inb_r.quat_w; qb = inb_r.quat_y; end
          default: begin qa = inb_r.quat_w; qb = inb_r.quat_z; end
        endcase
        mul_a = MUL_AW'(qa);
        mul_b = MUL_BW'(qb);
        if (!pend_r) begin
          mul_start = 1'b1;
          pend_nxt = 1'b1;
        end else if (mul_done) begin
          pend_nxt = 1'b0;
          qp_nxt[idx_r] = 32'(mul_p);
          if (idx_r == 4'd8) begin
            st_nxt = S_ROT;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end

      S_ROT: begin
        for (int i = 0; i < 9; i++) begin
          rot_nxt[i] = rot_round(raw[i]);
        end
        ax_nxt = '0;
        k_nxt = '0;
        acc_nxt = '0;
        if (!first_r && (dt > 32'(minint_r))) begin
          taken_nxt = 1'b1;
          st_nxt = S_RMUL;
        end else begin
          taken_nxt = 1'b0;
          st_nxt = S_MDIV;
        end
      end

      S_RMUL: begin
        // accumulate R(k,a) times the change of R(k,b)
        mul_a = MUL_AW'(diff);
        mul_b = MUL_BW'(rot_r[ia]);
        if (!pend_r) begin
          mul_start = 1'b1;
          pend_nxt = 1'b1;
        end else if (mul_done) begin
          pend_nxt = 1'b0;
          acc_nxt = acc_r + ACC_BITS'(mul_p);
          if (k_r == 2'd2) begin
            k_nxt = '0;
            st_nxt = S_SCALE;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end
      end

      S_SCALE: begin
        // scale the rounded magnitude to 1/1024 rad/s
        mul_a = MUL_AW'(s_val[S_BITS-1] ? -s_val : s_val);
        mul_b = RATE_MULT;
        if (!pend_r) begin
          mul_start = 1'b1;
          pend_nxt = 1'b1;
          sneg_nxt = s_val[S_BITS-1];
        end else if (mul_done) begin
          pend_nxt = 1'b0;
          scale_nxt = mul_p[DIV_NW-1:0];
          st_nxt = S_RDIV;
        end
      end

      S_RDIV: begin
        // (mag * scale + dt) / (2 dt) rounds half away from zero
        div_num = scale_r + DIV_NW'(dt);
        div_den = DIV_DW'({dt, 1'b0});
        if (!pend_r) begin
          div_start = 1'b1;
          pend_nxt = 1'b1;
        end else if (div_done) begin
          pend_nxt = 1'b0;
          sv = sat_signed(div_q, sneg_r, RATE_BITS);
          smp_nxt[ax_r] = sv[RATE_BITS-1:0];
          acc_nxt = '0;
          if (ax_r == 2'd2) begin
            ax_nxt = '0;
            st_nxt = S_UPD;
          end else begin
            ax_nxt = ax_r + 1'b1;
            st_nxt = S_RMUL;
          end
        end
      end

      S_UPD: begin
        // push the sample, evict the oldest when full
        hist_we = 1'b1;
        for (int a = 0; a < 3; a++) begin
          hist_wdata[a*RATE_BITS +: RATE_BITS] = smp_r[a];
          sums_nxt[a] = sums_r[a] + SUM_W'(smp_r[a])
                        - (full ? SUM_W'($signed(old_v[a])) : SUM_W'(0));
        end
        if (!full) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (CNT_W'(head_r) + 1'b1 == len_r) begin
          head_nxt = '0;
        end else begin
          head_nxt = head_r + 1'b1;
        end
        ax_nxt = '0;
        st_nxt = S_MDIV;
      end

      S_MDIV: begin
        // window mean, rounded half away from zero
        div_num = DIV_NW'(sum_mag) + DIV_NW'(cnt_r >> 1);
        div_den = DIV_DW'(cnt_r);
        if (cnt_r == '0) begin
          for (int a = 0; a < 3; a++) begin
            mean_nxt[a] = '0;
          end
          st_nxt = S_DONE;
        end else if (!pend_r) begin
          div_start = 1'b1;
          pend_nxt = 1'b1;
        end else if (div_done) begin
          pend_nxt = 1'b0;
          sv = sat_signed(div_q, sum_sel[SUM_W-1], OUT_BITS);
          mean_nxt[ax_r] = sv[OUT_BITS-1:0];
          if (ax_r == 2'd2) begin
            st_nxt = S_DONE;
          end else begin
            ax_nxt = ax_r + 1'b1;
          end
        end
      end

      S_DONE: begin
        // hand over once the output register is free
        if (!out_valid_r || !out_stall) begin
          out_nxt.rate_x = mean_r[0];
          out_nxt.rate_y = mean_r[1];
          out_nxt.rate_z = mean_r[2];
          out_nxt.rate_valid = (cnt_r != '0);
          out_nxt.sample_taken = taken_r;
          out_valid_nxt = 1'b1;
          prev_nxt = rot_r;
          pstamp_nxt = inb_r.stamp_us;
          first_nxt = 1'b0;
          st_nxt = S_IDLE;
        end
      end

      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      idx_r <= '0;
      ax_r <= '0;
      k_r <= '0;
      pend_r <= 1'b0;
      first_r <= 1'b1;
      taken_r <= 1'b0;
      len_r <= CNT_W'(LEN_RST);
      minint_r <= CFG_DATA_BITS'(1);
      head_r <= '0;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
      pstamp_r <= '0;
      for (int i = 0; i < 9; i++) begin
        prev_r[i] <= (i % 4 == 0) ? ROT_BITS'(1 << FRAC_BITS) : '0;
      end
      for (int a = 0; a < 3; a++) begin
        sums_r[a] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      idx_r <= idx_nxt;
      ax_r <= ax_nxt;
      k_r <= k_nxt;
      pend_r <= pend_nxt;
      first_r <= first_nxt;
      taken_r <= taken_nxt;
      len_r <= len_nxt;
      minint_r <= minint_nxt;
      head_r <= head_nxt;
      cnt_r <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      pstamp_r <= pstamp_nxt;
      prev_r <= prev_nxt;
      sums_r <= sums_nxt;
    end
    inb_r <= inb_nxt;
    qp_r <= qp_nxt;
    rot_r <= rot_nxt;
    smp_r <= smp_nxt;
    mean_r <= mean_nxt;
    acc_r <= acc_nxt;
    sneg_r <= sneg_nxt;
    scale_r <= scale_nxt;
    out_r <= out_nxt;
  end

  // history memory: one write port, registered read at the head
  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[head_r] <= hist_wdata;
    end
    hist_rd_r <= hist_mem[head_r];
  end

  assign in_stall = (st_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data = out_r;

endmodule
`default_nettype wire
